// File: design/dds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_pkg: shared types and constants for the density diffusion step block
// Grid geometry, bank sizing, beat payload structs and mode codes.
// ---------------------------------------------------------------------------
package dds_pkg;
    localparam int GRID_MAX_X   = 64;
    localparam int GRID_MAX_Y   = 64;
    localparam int DENSITY_BITS = 16;
    localparam int XW    = $clog2(GRID_MAX_X);
    localparam int YW    = $clog2(GRID_MAX_Y);
    localparam int AW    = XW + YW;
    localparam int CELLS = GRID_MAX_X * GRID_MAX_Y;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_COMPUTE = 2'd1;
    localparam logic [1:0] MODE_COMMIT  = 2'd2;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_BOUNDARY = 2'd2;
    localparam logic [1:0] REG_STEP     = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  bin_x;
        logic [5:0]  bin_y;
        logic [15:0] load_density;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] velocity_x;
        logic signed [15:0] velocity_y;
        logic [15:0]        new_density;
    } t_out_beat;
endpackage

// File: design/dds_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module dds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: design/dds_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dds_div: radix-2 restoring divider with velocity saturation
// Computes sat16(trunc(num / den)) for signed 25-bit num, unsigned 16-bit den,
// or zero when den is zero. One quotient bit per cycle.
// ---------------------------------------------------------------------------
module dds_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [24:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_done,
    output logic signed [15:0] o_quot
);
    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [23:0] r_q, n_q;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den, n_den;
    logic        r_neg, n_neg;
    logic        r_done, n_done;
    logic [17:0] w_trial;
    logic [24:0] w_mag;
    logic [24:0] w_sq;

    always_comb begin
        w_mag   = i_num[24] ? 25'(-i_num) : i_num;
        w_trial = {r_rem, r_q[23]} - {2'b0, r_den};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'd0;
            n_q    = w_mag[23:0];
            n_rem  = '0;
            n_den  = i_den;
            n_neg  = i_num[24];
        end else if (r_busy) begin
            if (!w_trial[17]) begin
                n_rem = w_trial[16:0];
                n_q   = {r_q[22:0], 1'b1};
            end else begin
                n_rem = {r_rem[15:0], r_q[23]};
                n_q   = {r_q[22:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        w_sq = r_neg ? 25'(-{1'b0, r_q}) : {1'b0, r_q};
        if (r_den == '0) begin
            o_quot = '0;
        end else if (!r_neg && r_q > 24'd32767) begin
            o_quot = 16'sd32767;
        end else if (r_neg && r_q > 24'd32768) begin
            o_quot = -16'sd32768;
        end else begin
            o_quot = w_sq[15:0];
        end
    end
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end
endmodule

// File: design/density_diffusion_stencil_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// density_diffusion_stencil_step: explicit 2D diffusion, five-point stencil
// Two density banks, per-bin velocity and diffused density, bank swap.
// ---------------------------------------------------------------------------
// A compute beat holds the input while it steps through serial reads of the
// active bank (one port, registered read), one multiply for dt*laplacian, a
// round and write of the shadow bank, then two divisions (24 quotient steps
// each) through one shared divider, and a load of the result register, which
// waits while the previous result is still held there. Load and commit finish
// at the accepting edge. The input is not ready while a compute beat is in
// work; one result register decouples the output side. Bank contents are
// undefined until loaded.
module density_diffusion_stencil_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  dds_pkg::t_in_beat    i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dds_pkg::t_out_beat   o_data,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);
    import dds_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_ND    = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_WX    = 4'd5;
    localparam logic [3:0] S_DIVY  = 4'd6;
    localparam logic [3:0] S_WY    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [6:0]  r_w, r_h;
    logic [15:0] r_bnd, r_dt;
    logic        r_bank;
    logic [3:0]  r_st;
    logic [2:0]  r_k;
    logic [5:0]  r_x, r_y;
    logic [15:0] r_nb [5];
    logic        r_nin [5];
    logic signed [35:0] r_acc;
    logic [15:0] r_nd;
    logic signed [15:0] r_vx, r_vy;
    logic        r_ov;
    t_out_beat   r_out;

    logic [6:0]  w_uw, w_uh;
    logic        w_acc_in;
    logic signed [7:0] w_nx, w_ny;
    logic        w_in;
    logic [AW-1:0] w_addr;
    logic        w_we_a, w_we_b;
    logic [15:0] w_wd, w_rd_a, w_rd_b, w_rd;
    logic [15:0] w_v [5];
    logic signed [18:0] w_lap;
    logic signed [36:0] w_acc;
    logic signed [36:0] w_sum;
    logic        w_dstart;
    logic signed [24:0] w_num;
    logic        w_ddone;
    logic signed [15:0] w_q;
    logic        w_wr_shadow;

    assign w_uw = (r_w > 7'(GRID_MAX_X)) ? 7'(GRID_MAX_X) : r_w;
    assign w_uh = (r_h > 7'(GRID_MAX_Y)) ? 7'(GRID_MAX_Y) : r_h;
    assign o_ready = (r_st == S_IDLE);
    assign w_acc_in = i_valid && o_ready;

    always_comb begin
        w_nx = {2'b0, r_x};
        w_ny = {2'b0, r_y};
        unique case (r_k)
            3'd1:    w_nx = w_nx - 8'sd1;
            3'd2:    w_nx = w_nx + 8'sd1;
            3'd3:    w_ny = w_ny + 8'sd1;
            3'd4:    w_ny = w_ny - 8'sd1;
            default: ;
        endcase
        w_in = (w_nx >= 0) && (w_ny >= 0) && (w_nx < $signed({1'b0, w_uw}))
            && (w_ny < $signed({1'b0, w_uh}));
    end

    assign w_wr_shadow = (r_st == S_ND);
    always_comb begin
        w_we_a = 1'b0;
        w_we_b = 1'b0;
        w_addr = {w_ny[YW-1:0], w_nx[XW-1:0]};
        w_wd   = i_data.load_density;
        if (w_acc_in && i_data.mode == MODE_LOAD) begin
            w_addr = {i_data.bin_y, i_data.bin_x};
            w_we_a = !r_bank;
            w_we_b = r_bank;
        end else if (w_wr_shadow) begin
            w_addr = {r_y, r_x};
            w_wd   = w_acc[36] ? '0 : (|w_sum[35:16] ? 16'hFFFF : w_sum[15:0]);
            w_we_a = r_bank;
            w_we_b = !r_bank;
        end
    end
    assign w_acc = 37'(r_acc);
    assign w_sum = (w_acc + 37'sd65536) >>> 17;

    dds_ram #(.WIDTH(16), .DEPTH(CELLS)) u_bank_a (
        .i_clk(i_clk), .i_we(w_we_a), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd_a));
    dds_ram #(.WIDTH(16), .DEPTH(CELLS)) u_bank_b (
        .i_clk(i_clk), .i_we(w_we_b), .i_addr(w_addr), .i_wdata(w_wd), .o_rdata(w_rd_b));
    assign w_rd = r_bank ? w_rd_b : w_rd_a;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_v[i] = r_nin[i] ? r_nb[i] : r_bnd;
        end
        w_lap = 19'(w_v[1]) + 19'(w_v[2]) + 19'(w_v[3]) + 19'(w_v[4])
            - 19'({w_v[0], 2'b0});
    end

    assign w_dstart = (r_st == S_ND) || (r_st == S_WX && w_ddone);
    assign w_num = (r_st == S_ND) ? 25'(-((25'(w_v[2]) - 25'(w_v[1])) <<< 7))
                                  : 25'(-((25'(w_v[3]) - 25'(w_v[4])) <<< 7));

    dds_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_num),
        .i_den(w_v[0]), .o_done(w_ddone), .o_quot(w_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= 7'd64;
            r_h    <= 7'd64;
            r_bnd  <= '0;
            r_dt   <= '0;
            r_bank <= 1'b0;
            r_st   <= S_IDLE;
            r_k    <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WIDTH:    r_w   <= i_cfg_data[6:0];
                    REG_HEIGHT:   r_h   <= i_cfg_data[6:0];
                    REG_BOUNDARY: r_bnd <= i_cfg_data;
                    REG_STEP:     r_dt  <= i_cfg_data;
                endcase
            end
            if (r_st == S_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (w_acc_in) begin
                        if (i_data.mode == MODE_COMMIT) begin
                            r_bank <= !r_bank;
                        end else if (i_data.mode == MODE_COMPUTE
                                     && {1'b0, i_data.bin_x} < w_uw
                                     && {1'b0, i_data.bin_y} < w_uh) begin
                            r_st <= S_RD;
                            r_k  <= '0;
                        end
                    end
                end
                S_RD: begin
                    if (r_k == 3'd5) begin
                        r_st <= S_MUL;
                    end
                    r_k <= r_k + 3'd1;
                end
                S_MUL:  r_st <= S_ND;
                S_ND:   r_st <= S_WX;
                S_WX:   if (w_ddone) r_st <= S_WY;
                S_WY:   if (w_ddone) r_st <= S_OUT;
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
        if (w_acc_in) begin
            r_x <= i_data.bin_x;
            r_y <= i_data.bin_y;
        end
        if (r_st == S_RD) begin
            if (r_k != 3'd5) r_nin[r_k] <= w_in;
            if (r_k != 3'd0) r_nb[r_k - 3'd1] <= w_rd;
        end
        if (r_st == S_MUL) begin
            r_acc <= 36'($signed({1'b0, w_v[0]}) <<< 17)
                + 36'($signed({1'b0, r_dt}) * w_lap);
        end
        if (r_st == S_ND) r_nd <= w_wd;
        if (r_st == S_WX && w_ddone) r_vx <= w_q;
        if (r_st == S_WY && w_ddone) r_vy <= w_q;
        if (r_st == S_OUT && (!r_ov || i_ready)) begin
            r_out.velocity_x  <= r_vx;
            r_out.velocity_y  <= r_vy;
            r_out.new_density <= r_nd;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> !o_ready)
        else $error("ready while a beat is in work");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped under stall");
    a_div_only_compute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> (r_st == S_WX || r_st == S_WY))
        else $error("divider finished outside compute");
endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: stimulus and checking for density_diffusion_stencil_step
// Runs a table of directed beats, then random load/compute/commit traffic
// over several grid settings. Loads are inserted ahead of a compute so that
// it never reads an unwritten bin. Every result beat is compared field by
// field against a behavioral stencil model or the typed row's own values.
// ---------------------------------------------------------------------------
module testbench;
    import dds_pkg::*;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  code;
        logic [5:0]  bx;
        logic [5:0]  by;
        logic [15:0] value;
        bit          typed;
        t_out_beat   want;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = REG_WIDTH;
    logic [15:0] i_cfg_data = '0;

    logic [15:0] bank_mem [2][CELLS];
    bit          written [2][CELLS];
    bit          live_bank;
    logic [6:0]  width_reg, height_reg;
    logic [15:0] edge_dens, dt_reg;

    t_out_beat   pending_q[$];
    t_row        rows[$];
    int          mismatches = 0;
    bit          calm = 1'b0;

    density_diffusion_stencil_step DUT (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        t_out_beat exp_beat;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h", o_data);
            end else begin
                exp_beat = pending_q.pop_front();
                if (o_data.velocity_x !== exp_beat.velocity_x
                        || o_data.velocity_y !== exp_beat.velocity_y
                        || o_data.new_density !== exp_beat.new_density) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: vx %0d/%0d vy %0d/%0d dens %h/%h (exp/act)",
                            exp_beat.velocity_x, o_data.velocity_x,
                            exp_beat.velocity_y, o_data.velocity_y,
                            exp_beat.new_density, o_data.new_density);
                end
            end
        end
    end

    function automatic longint bin_at(longint x, longint y);
        longint w, h;
        w = width_reg > GRID_MAX_X ? GRID_MAX_X : width_reg;
        h = height_reg > GRID_MAX_Y ? GRID_MAX_Y : height_reg;
        if (x < 0 || y < 0 || x >= w || y >= h)
            return edge_dens;
        return bank_mem[live_bank][y * GRID_MAX_X + x];
    endfunction

    function automatic logic [15:0] drift(longint hi, longint lo, longint d);
        longint q;
        if (d == 0)
            return 16'd0;
        q = (-(hi - lo) * 128) / d;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    // Updates model state; returns 1 when the beat yields a result.
    function automatic bit diffuse_step(input t_in_beat b, output t_out_beat r);
        longint x, y, d, l, rt, t, bt, lap, acc, nd, w, h;
        r = '0;
        case (b.mode)
            MODE_LOAD: begin
                bank_mem[live_bank][b.bin_y * GRID_MAX_X + b.bin_x] = b.load_density;
                written[live_bank][b.bin_y * GRID_MAX_X + b.bin_x] = 1'b1;
                return 1'b0;
            end
            MODE_COMMIT: begin
                live_bank = ~live_bank;
                return 1'b0;
            end
            MODE_COMPUTE: ;
            default: return 1'b0;
        endcase
        w = width_reg > GRID_MAX_X ? GRID_MAX_X : width_reg;
        h = height_reg > GRID_MAX_Y ? GRID_MAX_Y : height_reg;
        x = b.bin_x;
        y = b.bin_y;
        if (x >= w || y >= h)
            return 1'b0;
        d  = bin_at(x, y);
        l  = bin_at(x - 1, y);
        rt = bin_at(x + 1, y);
        t  = bin_at(x, y + 1);
        bt = bin_at(x, y - 1);
        lap = rt + l + t + bt - 4 * d;
        acc = d * 131072 + longint'(dt_reg) * lap;
        if (acc < 0) begin
            nd = 0;
        end else begin
            nd = (acc + 65536) >>> 17;
            if (nd > 65535)
                nd = 65535;
        end
        bank_mem[~live_bank][y * GRID_MAX_X + x] = nd[15:0];
        written[~live_bank][y * GRID_MAX_X + x] = 1'b1;
        r.velocity_x  = drift(rt, l, d);
        r.velocity_y  = drift(t, bt, d);
        r.new_density = nd[15:0];
        return 1'b1;
    endfunction

    // Returns at the accepting edge with valid still high.
    task automatic send_beat(input t_in_beat b, input bit typed, input t_out_beat want);
        int gap;
        t_out_beat r;
        gap = (!calm && $urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        forever begin
            @(negedge i_clk);
            if (o_ready)
                break;
        end
        @(posedge i_clk);
        if (diffuse_step(b, r))
            pending_q.push_back(typed ? want : r);
    endtask

    // Loads every unwritten in-grid bin that a compute at (x, y) would read.
    task automatic prefill(input logic [5:0] x, input logic [5:0] y, output int cnt);
        t_in_beat  lb;
        t_out_beat none;
        longint    px, py, w, h;
        none = '0;
        cnt  = 0;
        w = width_reg > GRID_MAX_X ? GRID_MAX_X : width_reg;
        h = height_reg > GRID_MAX_Y ? GRID_MAX_Y : height_reg;
        if (x >= w || y >= h)
            return;
        for (int k = 0; k < 5; k++) begin
            px = x;
            py = y;
            unique case (k)
                1:       px = px - 1;
                2:       px = px + 1;
                3:       py = py + 1;
                4:       py = py - 1;
                default: ;
            endcase
            if (px >= 0 && py >= 0 && px < w && py < h
                    && !written[live_bank][py * GRID_MAX_X + px]) begin
                lb.mode         = MODE_LOAD;
                lb.bin_x        = 6'(px);
                lb.bin_y        = 6'(py);
                lb.load_density = 16'($urandom);
                send_beat(lb, 1'b0, none);
                cnt++;
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_WIDTH:    width_reg  = val[6:0];
            REG_HEIGHT:   height_reg = val[6:0];
            REG_BOUNDARY: edge_dens  = val;
            default:      dt_reg     = val;
        endcase
    endtask

    function automatic t_row beat_row(logic [1:0] m, int x, int y, int v);
        t_row rw;
        rw = '{1'b0, m, x[5:0], y[5:0], v[15:0], 1'b0, '0};
        return rw;
    endfunction

    function automatic t_row cfg_row(logic [1:0] idx, int v);
        t_row rw;
        rw = '{1'b1, idx, 6'd0, 6'd0, v[15:0], 1'b0, '0};
        return rw;
    endfunction

    function automatic t_row typed_row(int x, int y, int vx, int vy, int nd);
        t_row rw;
        t_out_beat o;
        o.velocity_x  = vx[15:0];
        o.velocity_y  = vy[15:0];
        o.new_density = nd[15:0];
        rw = '{1'b0, MODE_COMPUTE, x[5:0], y[5:0], 16'd0, 1'b1, o};
        return rw;
    endfunction

    initial begin
        t_in_beat b;
        t_out_beat none;
        int w, h;
        int sent, extra;
        none = '0;
        live_bank  = 1'b0;
        width_reg  = 7'd64;
        height_reg = 7'd64;
        edge_dens  = '0;
        dt_reg     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back(cfg_row(REG_WIDTH, 1));
        rows.push_back(cfg_row(REG_HEIGHT, 1));
        rows.push_back(cfg_row(REG_BOUNDARY, 0));
        rows.push_back(cfg_row(REG_STEP, 0));
        rows.push_back(beat_row(MODE_LOAD, 0, 0, 0));
        rows.push_back(typed_row(0, 0, 0, 0, 0));
        rows.push_back(beat_row(MODE_LOAD, 0, 0, 16'hFFFF));
        rows.push_back(typed_row(0, 0, 0, 0, 16'hFFFF));
        rows.push_back(beat_row(MODE_COMPUTE, 1, 0, 0));
        rows.push_back(beat_row(2'd3, 63, 63, 16'hFFFF));
        rows.push_back(cfg_row(REG_BOUNDARY, 16'hFFFF));
        rows.push_back(cfg_row(REG_STEP, 16'hFFFF));
        rows.push_back(typed_row(0, 0, 0, 0, 16'hFFFF));
        rows.push_back(cfg_row(REG_WIDTH, 0));
        rows.push_back(beat_row(MODE_COMPUTE, 0, 0, 0));
        rows.push_back(cfg_row(REG_WIDTH, 127));
        rows.push_back(cfg_row(REG_HEIGHT, 127));
        rows.push_back(cfg_row(REG_BOUNDARY, 0));
        rows.push_back(beat_row(MODE_LOAD, 63, 63, 1));
        rows.push_back(beat_row(MODE_COMPUTE, 63, 63, 0));
        rows.push_back(beat_row(MODE_COMPUTE, 0, 0, 0));
        rows.push_back(beat_row(MODE_COMPUTE, 32, 17, 0));
        rows.push_back(beat_row(MODE_COMMIT, 0, 0, 0));
        rows.push_back(beat_row(MODE_COMPUTE, 63, 0, 0));
        rows.push_back(beat_row(MODE_COMMIT, 0, 0, 0));
        rows.push_back(beat_row(MODE_LOAD, 62, 5, 16'hFFFF));
        rows.push_back(beat_row(MODE_COMPUTE, 62, 5, 0));
        rows.push_back(beat_row(MODE_COMPUTE, 63, 5, 0));
        rows.push_back(beat_row(2'd3, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                write_reg(rows[i].code, rows[i].value);
            end else begin
                if (rows[i].code == MODE_COMPUTE)
                    prefill(rows[i].bx, rows[i].by, extra);
                b = '{rows[i].code, rows[i].bx, rows[i].by, rows[i].value};
                send_beat(b, rows[i].typed, rows[i].want);
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin w = 64; h = 64; end
                1: begin w = 1; h = 64; end
                2: begin w = 64; h = 1; end
                3: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
                default: begin w = $urandom_range(65, 127); h = $urandom_range(2, 8); end
            endcase
            write_reg(REG_WIDTH, 16'(w));
            write_reg(REG_HEIGHT, 16'(h));
            write_reg(REG_BOUNDARY, ph == 1 ? 16'hFFFF : (ph == 2 ? 16'h0 : 16'($urandom)));
            write_reg(REG_STEP, ph == 2 ? 16'hFFFF : 16'($urandom));
            if (w > GRID_MAX_X)
                w = GRID_MAX_X;
            calm = (ph == 0);
            sent = 0;
            while (sent < 140) begin
                int sel;
                sel = $urandom_range(0, 99);
                b.load_density = 16'($urandom);
                b.bin_x = 6'($urandom);
                b.bin_y = 6'($urandom);
                if (sel < 50) begin
                    b.mode = MODE_COMPUTE;
                    if (sel < 42) begin
                        b.bin_x = 6'($urandom_range(0, w - 1));
                        b.bin_y = 6'($urandom_range(0, h - 1));
                    end
                end else if (sel < 85) begin
                    b.mode = MODE_LOAD;
                    if (sel < 75) begin
                        b.bin_x = 6'($urandom_range(0, w - 1));
                        b.bin_y = 6'($urandom_range(0, h - 1));
                    end
                end else if (sel < 95) begin
                    b.mode = MODE_COMMIT;
                end else begin
                    b.mode = 2'd3;
                end
                if (b.mode == MODE_COMPUTE) begin
                    prefill(b.bin_x, b.bin_y, extra);
                    sent += extra;
                end
                send_beat(b, 1'b0, none);
                sent++;
            end
            calm = 1'b0;
        end

        i_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
